>>> hdl/tte_pkg.sv
package tte_pkg;

  localparam int CALC_W      = 10;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  localparam logic CFG_AUTO_SCROLL  = 1'b0;
  localparam logic CFG_DEFAULT_ATTR = 1'b1;

  typedef enum logic [3:0] {
    OP_PUT      = 4'd0,
    OP_BACK     = 4'd1,
    OP_ENTER    = 4'd2,
    OP_SET_CUR  = 4'd3,
    OP_UP       = 4'd4,
    OP_DOWN     = 4'd5,
    OP_SCROLL_TO = 4'd6,
    OP_BOTTOM   = 4'd7,
    OP_CLEAR    = 4'd8,
    OP_CLR_LINE = 4'd9,
    OP_COLOUR   = 4'd10,
    OP_READ     = 4'd11,
    OP_NOP      = 4'd12
  } op_t;

  typedef enum logic [1:0] {
    CH_PRINT,
    CH_NL,
    CH_CR,
    CH_TAB
  } char_cls_t;

  typedef struct packed {
    op_t        op;
    char_cls_t  cls;
    logic [7:0] ch;
    logic [6:0] col;
    logic [7:0] row;
    logic [7:0] cnt;
    logic [7:0] attr;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_FILL,
    ST_RMW,
    ST_READ,
    ST_DONE
  } bstate_t;

endpackage

>>> hdl/tte_ram.sv
module tte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 5120
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/tte_front.sv
module tte_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [3:0]    in_command,
  input  logic [7:0]    in_character,
  input  logic [6:0]    in_column,
  input  logic [7:0]    in_row,
  input  logic [7:0]    in_line_count,
  input  logic [7:0]    in_attribute,
  input  logic          init_active,
  output logic          q_valid,
  output tte_pkg::cmd_t q_item,
  input  logic          q_pop
);
  import tte_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  cmd_t          dec;
  logic          push;

  // classify the command and character
  always_comb begin
    dec.ch   = in_character;
    dec.col  = in_column;
    dec.row  = in_row;
    dec.cnt  = in_line_count;
    dec.attr = in_attribute;
    case (op_t'(in_command))
      OP_PUT, OP_BACK, OP_ENTER, OP_SET_CUR, OP_UP, OP_DOWN, OP_SCROLL_TO, OP_BOTTOM,
      OP_CLEAR, OP_CLR_LINE, OP_COLOUR, OP_READ: dec.op = op_t'(in_command);
      default: dec.op = OP_NOP;
    endcase
    case (in_character)
      CHAR_NL:  dec.cls = CH_NL;
      CHAR_CR:  dec.cls = CH_CR;
      CHAR_TAB: dec.cls = CH_TAB;
      default:  dec.cls = CH_PRINT;
    endcase
  end

  assign busy    = (cnt_r == NW'(QUEUE_DEPTH)) || init_active;
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec;
    end
  end

endmodule

>>> hdl/tte_back.sv
module tte_back #(
  parameter int COLUMNS        = 80,
  parameter int BUFFER_ROWS    = 64,
  parameter int SCREEN_ROWS    = 25,
  parameter int SCREEN_COLUMNS = 80
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          auto_scroll_en,
  input  logic [7:0]    default_attr,
  input  logic          q_valid,
  input  tte_pkg::cmd_t q_item,
  output logic          q_pop,
  output logic          init_active,
  output logic          out_valid,
  output logic          out_status,
  output logic [6:0]    out_cursor_column,
  output logic [5:0]    out_cursor_row,
  output logic [5:0]    out_view_offset,
  output logic [7:0]    out_cell_character,
  output logic [7:0]    out_cell_attribute,
  output logic          out_cursor_shown,
  output logic [4:0]    out_cursor_view_row
);
  import tte_pkg::*;

  localparam int RW      = $clog2(BUFFER_ROWS);
  localparam int RW1     = RW + 1;
  localparam int AW      = $clog2(BUFFER_ROWS * COLUMNS);
  localparam int MAX_OFF = (BUFFER_ROWS > SCREEN_ROWS) ? BUFFER_ROWS - SCREEN_ROWS : 0;

  localparam logic [CALC_W-1:0] C_COLS = CALC_W'(COLUMNS);
  localparam logic [CALC_W-1:0] C_BR   = CALC_W'(BUFFER_ROWS);
  localparam logic [CALC_W-1:0] C_SR   = CALC_W'(SCREEN_ROWS);
  localparam logic [CALC_W-1:0] C_SC   = CALC_W'(SCREEN_COLUMNS);
  localparam logic [CALC_W-1:0] C_MAX  = CALC_W'(MAX_OFF);
  localparam logic [RW-1:0]     LAST_ROW = RW'(BUFFER_ROWS - 1);
  localparam logic [6:0]        LAST_COL = 7'(COLUMNS - 1);

  bstate_t       state_r, state_nxt;
  logic [6:0]    col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [RW-1:0] scroll_r, scroll_nxt;
  logic [RW-1:0] base_r, base_nxt;
  logic [7:0]    colour_r, colour_nxt;
  logic [RW-1:0] fill_row_r, fill_row_nxt;
  logic [6:0]    fill_col_r, fill_col_nxt;
  logic          fill_all_r, fill_all_nxt;
  logic [7:0]    fill_attr_r, fill_attr_nxt;
  logic          fill_put_r, fill_put_nxt;
  logic [7:0]    fill_ch_r, fill_ch_nxt;
  logic          status_r, status_nxt;
  logic [7:0]    cell_ch_r, cell_ch_nxt;
  logic [7:0]    cell_at_r, cell_at_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic [AW-1:0] rmw_addr_r, rmw_addr_nxt;

  logic          out_valid_r;
  logic          out_status_r;
  logic [6:0]    out_col_r;
  logic [5:0]    out_row_r;
  logic [5:0]    out_off_r;
  logic [7:0]    out_ch_r;
  logic [7:0]    out_at_r;
  logic          out_shown_r;
  logic [4:0]    out_srow_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;

  logic              nl, put, ent;
  logic [CALC_W-1:0] t;
  logic [RW-1:0]     nrow;
  logic [6:0]        wcol;
  logic              shown;
  logic [CALC_W-1:0] srow;

  function automatic logic [RW-1:0] phys_row(logic [RW-1:0] lrow, logic [RW-1:0] base);
    logic [RW1-1:0] s;
    s = {1'b0, lrow} + {1'b0, base};
    if (s >= RW1'(BUFFER_ROWS)) begin
      s = s - RW1'(BUFFER_ROWS);
    end
    return s[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] prow, logic [6:0] c);
    return AW'(AW'(prow) * AW'(COLUMNS)) + AW'(c);
  endfunction

  tte_ram #(
    .WIDTH(16),
    .DEPTH(BUFFER_ROWS * COLUMNS)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    scroll_nxt    = scroll_r;
    base_nxt      = base_r;
    colour_nxt    = colour_r;
    fill_row_nxt  = fill_row_r;
    fill_col_nxt  = fill_col_r;
    fill_all_nxt  = fill_all_r;
    fill_attr_nxt = fill_attr_r;
    fill_put_nxt  = fill_put_r;
    fill_ch_nxt   = fill_ch_r;
    status_nxt    = status_r;
    cell_ch_nxt   = cell_ch_r;
    cell_at_nxt   = cell_at_r;
    rd_ok_nxt     = rd_ok_r;
    rmw_addr_nxt  = rmw_addr_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;
    q_pop         = 1'b0;
    nl            = 1'b0;
    put           = 1'b0;
    ent           = 1'b0;
    t             = '0;
    nrow          = row_r;
    wcol          = col_r;
    case (state_r)
      ST_INIT, ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(fill_row_r, fill_col_r);
        mem_wdata = (fill_put_r && fill_col_r == '0) ? {fill_attr_r, fill_ch_r}
                                                     : {fill_attr_r, CHAR_SPACE};
        if (fill_col_r == LAST_COL) begin
          fill_col_nxt = '0;
          fill_put_nxt = 1'b0;
          if (fill_all_r && fill_row_r != LAST_ROW) begin
            fill_row_nxt = fill_row_r + 1'b1;
          end else begin
            state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_DONE;
          end
        end else begin
          fill_col_nxt = fill_col_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          state_nxt   = ST_DONE;
          status_nxt  = 1'b0;
          cell_ch_nxt = '0;
          cell_at_nxt = '0;
          case (q_item.op)
            OP_PUT: begin
              case (q_item.cls)
                CH_NL: nl = 1'b1;
                CH_CR: col_nxt = '0;
                CH_TAB: begin
                  t = (CALC_W'(col_r) + CALC_W'(4)) & ~CALC_W'(3);
                  if (t >= C_COLS) begin
                    nl = 1'b1;
                  end else begin
                    col_nxt = 7'(t);
                  end
                end
                default: begin
                  put = 1'b1;
                  if (CALC_W'(col_r) >= C_COLS) begin
                    nl = 1'b1;
                  end
                end
              endcase
            end
            OP_BACK: begin
              if (col_r != '0) begin
                col_nxt      = col_r - 1'b1;
                mem_raddr    = cell_addr(phys_row(row_r, base_r), col_r - 1'b1);
                rmw_addr_nxt = mem_raddr;
                state_nxt    = ST_RMW;
              end
            end
            OP_ENTER: begin
              nl  = 1'b1;
              ent = 1'b1;
            end
            OP_SET_CUR: begin
              col_nxt = (CALC_W'(q_item.col) >= C_COLS) ? LAST_COL : q_item.col;
              row_nxt = (CALC_W'(q_item.row) >= C_BR) ? LAST_ROW : RW'(q_item.row);
            end
            OP_UP: begin
              if (q_item.cnt != '0) begin
                t = (CALC_W'(scroll_r) >= CALC_W'(q_item.cnt))
                    ? CALC_W'(scroll_r) - CALC_W'(q_item.cnt) : '0;
                scroll_nxt = RW'(t);
              end
            end
            OP_DOWN: begin
              if (q_item.cnt != '0) begin
                t = CALC_W'(scroll_r) + CALC_W'(q_item.cnt);
                scroll_nxt = (t > C_MAX) ? RW'(C_MAX) : RW'(t);
              end
            end
            OP_SCROLL_TO: begin
              scroll_nxt = (CALC_W'(q_item.row) > C_MAX) ? RW'(C_MAX) : RW'(q_item.row);
            end
            OP_BOTTOM: scroll_nxt = RW'(C_MAX);
            OP_CLEAR: begin
              fill_row_nxt  = '0;
              fill_col_nxt  = '0;
              fill_all_nxt  = 1'b1;
              fill_attr_nxt = default_attr;
              fill_put_nxt  = 1'b0;
              base_nxt      = '0;
              col_nxt       = '0;
              row_nxt       = '0;
              scroll_nxt    = '0;
              state_nxt     = ST_FILL;
            end
            OP_CLR_LINE: begin
              if (CALC_W'(q_item.row) >= C_BR) begin
                status_nxt = 1'b1;
              end else begin
                fill_row_nxt  = phys_row(RW'(q_item.row), base_r);
                fill_col_nxt  = '0;
                fill_all_nxt  = 1'b0;
                fill_attr_nxt = default_attr;
                fill_put_nxt  = 1'b0;
                state_nxt     = ST_FILL;
              end
            end
            OP_COLOUR: colour_nxt = q_item.attr;
            OP_READ: begin
              t = CALC_W'(scroll_r) + CALC_W'(q_item.row);
              rd_ok_nxt = (CALC_W'(q_item.row) < C_SR) && (CALC_W'(q_item.col) < C_SC) &&
                          (CALC_W'(q_item.col) < C_COLS) && (t < C_BR);
              mem_raddr = cell_addr(phys_row(RW'(t), base_r), q_item.col);
              state_nxt = ST_READ;
            end
            default: begin
            end
          endcase

          // newline, with store shift on the last row
          if (nl) begin
            col_nxt = '0;
            wcol    = '0;
            if (row_r == LAST_ROW) begin
              base_nxt      = (base_r == LAST_ROW) ? '0 : base_r + 1'b1;
              fill_row_nxt  = base_r;
              fill_col_nxt  = '0;
              fill_all_nxt  = 1'b0;
              fill_attr_nxt = colour_r;
              fill_put_nxt  = put;
              fill_ch_nxt   = q_item.ch;
              state_nxt     = ST_FILL;
            end else begin
              nrow    = row_r + 1'b1;
              row_nxt = nrow;
            end
          end

          if (put) begin
            if (!(nl && row_r == LAST_ROW)) begin
              mem_we    = 1'b1;
              mem_waddr = cell_addr(phys_row(nrow, base_r), wcol);
              mem_wdata = {colour_r, q_item.ch};
            end
            col_nxt = wcol + 1'b1;
            if (auto_scroll_en &&
                (CALC_W'(nrow) + CALC_W'(2) >= CALC_W'(scroll_r) + C_SR)) begin
              scroll_nxt = (CALC_W'(scroll_r) >= C_MAX) ? RW'(C_MAX) : scroll_r + 1'b1;
            end
          end

          if (ent && (CALC_W'(nrow) >= CALC_W'(scroll_r) + C_SR)) begin
            t = CALC_W'(nrow) + CALC_W'(1) - C_SR;
            scroll_nxt = (t > C_MAX) ? RW'(C_MAX) : RW'(t);
          end
        end
      end
      ST_RMW: begin
        mem_we    = 1'b1;
        mem_waddr = rmw_addr_r;
        mem_wdata = {mem_rdata[15:8], CHAR_SPACE};
        state_nxt = ST_DONE;
      end
      ST_READ: begin
        cell_ch_nxt = rd_ok_r ? mem_rdata[7:0] : CHAR_SPACE;
        cell_at_nxt = rd_ok_r ? mem_rdata[15:8] : default_attr;
        state_nxt   = ST_DONE;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // cursor visibility
  always_comb begin
    shown = (CALC_W'(row_r) >= CALC_W'(scroll_r)) &&
            (CALC_W'(row_r) < CALC_W'(scroll_r) + C_SR) &&
            (CALC_W'(col_r) < C_SC);
    srow  = shown ? CALC_W'(row_r) - CALC_W'(scroll_r) : C_SR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      col_r       <= '0;
      row_r       <= '0;
      scroll_r    <= '0;
      base_r      <= '0;
      colour_r    <= ATTR_RESET;
      fill_row_r  <= '0;
      fill_col_r  <= '0;
      fill_all_r  <= 1'b1;
      fill_attr_r <= ATTR_RESET;
      fill_put_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      scroll_r    <= scroll_nxt;
      base_r      <= base_nxt;
      colour_r    <= colour_nxt;
      fill_row_r  <= fill_row_nxt;
      fill_col_r  <= fill_col_nxt;
      fill_all_r  <= fill_all_nxt;
      fill_attr_r <= fill_attr_nxt;
      fill_put_r  <= fill_put_nxt;
      out_valid_r <= (state_r == ST_DONE);
    end
  end

  always_ff @(posedge clk) begin
    fill_ch_r  <= fill_ch_nxt;
    status_r   <= status_nxt;
    cell_ch_r  <= cell_ch_nxt;
    cell_at_r  <= cell_at_nxt;
    rd_ok_r    <= rd_ok_nxt;
    rmw_addr_r <= rmw_addr_nxt;
    if (state_r == ST_DONE) begin
      out_status_r <= status_r;
      out_col_r    <= col_r;
      out_row_r    <= 6'(row_r);
      out_off_r    <= 6'(scroll_r);
      out_ch_r     <= cell_ch_r;
      out_at_r     <= cell_at_r;
      out_shown_r  <= shown;
      out_srow_r   <= 5'(srow);
    end
  end

  assign init_active         = (state_r == ST_INIT);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_cursor_column   = out_col_r;
  assign out_cursor_row      = out_row_r;
  assign out_view_offset     = out_off_r;
  assign out_cell_character  = out_ch_r;
  assign out_cell_attribute  = out_at_r;
  assign out_cursor_shown    = out_shown_r;
  assign out_cursor_view_row = out_srow_r;

endmodule

>>> hdl/text_terminal_cell_engine.sv
// Text terminal cell engine. A command is taken when start is high and busy is low; its
// result appears on the out_ ports for one cycle with out_valid, and the receiver cannot
// stall it. A two-entry command queue sits in front of the execution engine. Most commands
// go from IDLE to DONE, and a new one is taken only after DONE. Read cell, and backspace
// at a non-zero column, add a READ or RMW state, as the cell RAM read is registered. Clear
// line, and a newline on the last store row (the rows rotate and the new bottom row is
// filled) fill one row, one cell per cycle; clear all fills every row. After reset
// a clearing pass writes all BUFFER_ROWS * COLUMNS cells (5120 by default) while busy is
// held high; configuration writes are taken at any time on the cfg_ port.
module text_terminal_cell_engine #(
  parameter int COLUMNS        = 80,
  parameter int BUFFER_ROWS    = 64,
  parameter int SCREEN_ROWS    = 25,
  parameter int SCREEN_COLUMNS = 80
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [3:0] in_command,
  input  logic [7:0] in_character,
  input  logic [6:0] in_column,
  input  logic [7:0] in_row,
  input  logic [7:0] in_line_count,
  input  logic [7:0] in_attribute,
  output logic       out_valid,
  output logic       out_status,
  output logic [6:0] out_cursor_column,
  output logic [5:0] out_cursor_row,
  output logic [5:0] out_view_offset,
  output logic [7:0] out_cell_character,
  output logic [7:0] out_cell_attribute,
  output logic       out_cursor_shown,
  output logic [4:0] out_cursor_view_row,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import tte_pkg::*;

  logic       auto_scroll_r;
  logic [7:0] default_attr_r;
  logic       init_active;
  logic       q_valid;
  cmd_t       q_item;
  logic       q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_scroll_r  <= 1'b1;
      default_attr_r <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_AUTO_SCROLL:  auto_scroll_r  <= cfg_data[0];
        CFG_DEFAULT_ATTR: default_attr_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tte_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_character (in_character),
    .in_column    (in_column),
    .in_row       (in_row),
    .in_line_count(in_line_count),
    .in_attribute (in_attribute),
    .init_active  (init_active),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  tte_back #(
    .COLUMNS       (COLUMNS),
    .BUFFER_ROWS   (BUFFER_ROWS),
    .SCREEN_ROWS   (SCREEN_ROWS),
    .SCREEN_COLUMNS(SCREEN_COLUMNS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .auto_scroll_en     (auto_scroll_r),
    .default_attr       (default_attr_r),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .init_active        (init_active),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_cursor_column  (out_cursor_column),
    .out_cursor_row     (out_cursor_row),
    .out_view_offset    (out_view_offset),
    .out_cell_character (out_cell_character),
    .out_cell_attribute (out_cell_attribute),
    .out_cursor_shown   (out_cursor_shown),
    .out_cursor_view_row(out_cursor_view_row)
  );

  a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_active |-> !out_valid)
    else $error("result during clearing pass");

  a_hidden_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_cursor_shown) |-> (out_cursor_view_row == 5'(SCREEN_ROWS)))
    else $error("hidden cursor has a screen row");

  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results back to back");

  a_busy_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_active |-> busy)
    else $error("command taken during clearing pass");

endmodule
